// ----- rtl/rwh_pkg.sv -----
// Shared types and constants for the RIFF WAVE header parser.
package rwh_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] FMT_BYTES = 32'd16;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_WAVE    = 3'd1;
  localparam logic [2:0] ST_BAD_FMT     = 3'd2;
  localparam logic [2:0] ST_NO_DATA     = 3'd3;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd4;

  localparam logic [1:0] REG_WANTED_FORMAT      = 2'd0;
  localparam logic [1:0] REG_WANTED_SAMPLE_BITS = 2'd1;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_size;
    logic [31:0] data_offset;
  } result_t;

endpackage

// ----- rtl/rwh_core.sv -----
// Byte-at-a-time chunk walker: parse state and per-byte next-state logic.
module rwh_core import rwh_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    byte_value,
  input  logic          first_byte,
  input  logic          last_byte,
  input  logic [15:0]   wanted_format,
  input  logic [15:0]   wanted_sample_bits,
  output logic          emit,
  output result_t       result
);

  localparam logic [2:0] PH_RIFF  = 3'd0;
  localparam logic [2:0] PH_RSIZE = 3'd1;
  localparam logic [2:0] PH_WAVE  = 3'd2;
  localparam logic [2:0] PH_HDR   = 3'd3;
  localparam logic [2:0] PH_FMT   = 3'd4;
  localparam logic [2:0] PH_SKIP  = 3'd5;
  localparam logic [2:0] PH_PAD   = 3'd6;

  logic [2:0]       phase, phase_next;
  logic [3:0]       byte_index, byte_index_next;
  logic [31:0]      chunk_tag, chunk_tag_next;
  logic [31:0]      chunk_length, chunk_length_next;
  logic [31:0]      skip_remaining, skip_remaining_next;
  logic [31:0]      file_position, file_position_next;
  logic [15:0][7:0] fmt_bytes, fmt_bytes_next;
  logic             format_seen, format_seen_next;
  logic             finished, finished_next;

  // state as seen by this byte: a first byte restarts the file
  logic [2:0]       cur_phase;
  logic [3:0]       cur_index;
  logic [31:0]      cur_tag, cur_length, cur_skip, cur_pos;
  logic [15:0][7:0] cur_fmt;
  logic             cur_seen, cur_finished;

  logic [4:0]       index_inc;
  logic [31:0]      length_base;
  logic [2:0]       status;
  logic             report;

  function automatic logic [2:0] after_body(input logic [31:0] skip, input logic len_odd);
    if (skip != 32'd0) return PH_SKIP;
    else if (len_odd)  return PH_PAD;
    else               return PH_HDR;
  endfunction

  always_comb begin
    cur_phase    = first_byte ? PH_RIFF : phase;
    cur_index    = first_byte ? 4'd0 : byte_index;
    cur_tag      = first_byte ? 32'd0 : chunk_tag;
    cur_length   = first_byte ? 32'd0 : chunk_length;
    cur_skip     = first_byte ? 32'd0 : skip_remaining;
    cur_pos      = first_byte ? 32'd0 : file_position;
    cur_fmt      = first_byte ? '0 : fmt_bytes;
    cur_seen     = first_byte ? 1'b0 : format_seen;
    cur_finished = first_byte ? 1'b0 : finished;
  end

  always_comb begin
    phase_next          = cur_phase;
    byte_index_next     = cur_index;
    chunk_tag_next      = cur_tag;
    chunk_length_next   = cur_length;
    skip_remaining_next = cur_skip;
    file_position_next  = cur_pos;
    fmt_bytes_next      = cur_fmt;
    format_seen_next    = cur_seen;
    finished_next       = cur_finished;
    emit                = 1'b0;
    status              = ST_OK;
    report              = 1'b0;
    index_inc           = {1'b0, cur_index} + 5'd1;
    length_base         = (cur_index == 4'd0) ? 32'd0 : cur_length;

    if (!cur_finished) begin
      file_position_next = cur_pos + 32'd1;
      unique case (cur_phase) inside
        PH_RIFF, PH_WAVE: begin
          chunk_tag_next  = {cur_tag[23:0], byte_value};
          byte_index_next = index_inc[3:0];
          if (index_inc >= 5'd4) begin
            byte_index_next = 4'd0;
            if (chunk_tag_next != ((cur_phase == PH_RIFF) ? TAG_RIFF : TAG_WAVE)) begin
              emit   = 1'b1;
              status = ST_NOT_WAVE;
            end else begin
              phase_next = (cur_phase == PH_RIFF) ? PH_RSIZE : PH_HDR;
            end
          end
        end
        PH_RSIZE: begin
          byte_index_next = index_inc[3:0];
          if (index_inc >= 5'd4) begin
            byte_index_next = 4'd0;
            phase_next      = PH_WAVE;
          end
        end
        PH_HDR: begin
          chunk_length_next = length_base;
          if (cur_index < 4'd4) begin
            chunk_tag_next = {cur_tag[23:0], byte_value};
          end else begin
            chunk_length_next = length_base |
                                ({24'd0, byte_value} << {cur_index[1:0], 3'b000});
          end
          byte_index_next = index_inc[3:0];
          if (index_inc >= 5'd8) begin
            byte_index_next = 4'd0;
            if (chunk_tag_next == TAG_FMT) begin
              if (chunk_length_next < FMT_BYTES) begin
                emit   = 1'b1;
                status = ST_BAD_FMT;
              end else begin
                phase_next = PH_FMT;
              end
            end else if (chunk_tag_next == TAG_DATA) begin
              emit   = 1'b1;
              report = 1'b1;
              if (!cur_seen || {cur_fmt[1], cur_fmt[0]} != wanted_format ||
                  {cur_fmt[15], cur_fmt[14]} != wanted_sample_bits) begin
                status = ST_UNSUPPORTED;
              end
            end else begin
              skip_remaining_next = chunk_length_next;
              phase_next = after_body(chunk_length_next, chunk_length_next[0]);
            end
          end
        end
        PH_FMT: begin
          fmt_bytes_next[cur_index] = byte_value;
          byte_index_next = index_inc[3:0];
          if (index_inc[4]) begin
            byte_index_next     = 4'd0;
            format_seen_next    = 1'b1;
            skip_remaining_next = cur_length - FMT_BYTES;
            phase_next = after_body(skip_remaining_next, cur_length[0]);
          end
        end
        PH_SKIP: begin
          skip_remaining_next = cur_skip - 32'd1;
          if (skip_remaining_next == 32'd0) begin
            phase_next = cur_length[0] ? PH_PAD : PH_HDR;
          end
        end
        default: begin
          // pad byte: drop it and go to the next chunk header
          phase_next      = PH_HDR;
          byte_index_next = 4'd0;
        end
      endcase

      if (last_byte && !emit) begin
        emit   = 1'b1;
        status = (phase_next <= PH_WAVE) ? ST_NOT_WAVE : ST_NO_DATA;
      end
      if (emit) begin
        finished_next = 1'b1;
      end
    end

    result.status = status;
    if (report) begin
      result.audio_format  = {cur_fmt[1], cur_fmt[0]};
      result.channel_count = {cur_fmt[3], cur_fmt[2]};
      result.sample_rate   = {cur_fmt[7], cur_fmt[6], cur_fmt[5], cur_fmt[4]};
      result.byte_rate     = {cur_fmt[11], cur_fmt[10], cur_fmt[9], cur_fmt[8]};
      result.block_align   = {cur_fmt[13], cur_fmt[12]};
      result.sample_bits   = {cur_fmt[15], cur_fmt[14]};
      result.data_size     = chunk_length_next;
      result.data_offset   = file_position_next;
    end else begin
      result.audio_format  = 16'd0;
      result.channel_count = 16'd0;
      result.sample_rate   = 32'd0;
      result.byte_rate     = 32'd0;
      result.block_align   = 16'd0;
      result.sample_bits   = 16'd0;
      result.data_size     = 32'd0;
      result.data_offset   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RIFF;
      byte_index     <= 4'd0;
      chunk_tag      <= 32'd0;
      chunk_length   <= 32'd0;
      skip_remaining <= 32'd0;
      file_position  <= 32'd0;
      fmt_bytes      <= '0;
      format_seen    <= 1'b0;
      finished       <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_index     <= byte_index_next;
      chunk_tag      <= chunk_tag_next;
      chunk_length   <= chunk_length_next;
      skip_remaining <= skip_remaining_next;
      file_position  <= file_position_next;
      fmt_bytes      <= fmt_bytes_next;
      format_seen    <= format_seen_next;
      finished       <= finished_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    finished |-> (phase != PH_RIFF || byte_index != 4'd0 || file_position != 32'd0))
    else $error("finished parse with no byte consumed");

endmodule

// ----- rtl/riff_wave_header_parser.sv -----
// Top level of the RIFF WAVE header parser: config registers and result register.
// result_valid is registered: it rises the cycle after the completing byte is accepted.
// Throughput: one byte per cycle, held off by byte_stall while a result waits under
// result_stall; both registers update on the accepted byte, so bytes flow as it drains.
// Reset: clears the parse state and the result valid flag; wanted_format resets to 3 and
// wanted_sample_bits to 32.
module riff_wave_header_parser import rwh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  byte_value,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [15:0] audio_format,
  output logic [15:0] channel_count,
  output logic [31:0] sample_rate,
  output logic [31:0] byte_rate,
  output logic [15:0] block_align,
  output logic [15:0] sample_bits,
  output logic [31:0] data_size,
  output logic [31:0] data_offset,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] wanted_format;
  logic [15:0] wanted_sample_bits;
  logic        accept;
  logic        emit;
  result_t     core_result;
  result_t     result;

  assign cfg_ready  = 1'b1;
  // hold off bytes only while a result waits and the sink is stalled
  assign byte_stall = result_valid & result_stall;
  assign accept     = byte_valid & ~byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_format      <= 16'd3;
      wanted_sample_bits <= 16'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WANTED_FORMAT:      wanted_format      <= cfg_data;
        REG_WANTED_SAMPLE_BITS: wanted_sample_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  rwh_core u_core (
    .clk                (clk),
    .rst                (rst),
    .accept             (accept),
    .byte_value         (byte_value),
    .first_byte         (first_byte),
    .last_byte          (last_byte),
    .wanted_format      (wanted_format),
    .wanted_sample_bits (wanted_sample_bits),
    .emit               (emit),
    .result             (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= core_result;
    end
  end

  assign status        = result.status;
  assign audio_format  = result.audio_format;
  assign channel_count = result.channel_count;
  assign sample_rate   = result.sample_rate;
  assign byte_rate     = result.byte_rate;
  assign block_align   = result.block_align;
  assign sample_bits   = result.sample_bits;
  assign data_size     = result.data_size;
  assign data_offset   = result.data_offset;

  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (status == ST_OK || status == ST_NOT_WAVE || status == ST_BAD_FMT ||
                      status == ST_NO_DATA || status == ST_UNSUPPORTED))
    else $error("undefined status code");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_NOT_WAVE || status == ST_BAD_FMT || status == ST_NO_DATA)
      |-> (data_size == 32'd0 && data_offset == 32'd0 && audio_format == 16'd0))
    else $error("error result carries field values");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_OK
      |-> (audio_format == wanted_format && sample_bits == wanted_sample_bits))
    else $error("ok result with mismatched format");

endmodule
